/* rtl/core/gdjs_pkg.sv */
`default_nettype none
package gdjs_pkg;
    localparam int MaxJobs  = 64;
    localparam int MaxSlots = 16;
    localparam int IdxW     = $clog2(MaxJobs);
    localparam int CntW     = $clog2(MaxJobs + 1);
    localparam int SlotW    = 5;
    localparam int DlW      = 8;
    localparam int PayW     = 16;
    localparam int KeyW     = 16;
    localparam logic [SlotW-1:0] MaxTimeReset = 5'd5;

    typedef struct packed {
        logic [DlW-1:0]  deadline;
        logic [PayW-1:0] payment;
        logic [KeyW-1:0] key;
    } t_job;
endpackage
`default_nettype wire

/* rtl/core/gdjs_divider.sv */
`default_nettype none
module gdjs_divider (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [gdjs_pkg::PayW-1:0] i_num,
    input  wire logic [gdjs_pkg::DlW-1:0]  i_den,
    output logic                         o_done,
    output logic [gdjs_pkg::KeyW-1:0]    o_quot
);
    import gdjs_pkg::*;

    logic [PayW-1:0] r_q, n_q;
    logic [DlW:0]    r_rem, n_rem;
    logic [DlW-1:0]  r_den;
    logic [4:0]      r_cnt;
    logic            r_busy;
    logic [DlW:0]    trial;

    // One quotient bit per cycle, restoring.
    always_comb begin
        trial = {r_rem[DlW-1:0], r_q[PayW-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = trial - {1'b0, r_den};
            n_q   = {r_q[PayW-2:0], 1'b1};
        end else begin
            n_rem = trial;
            n_q   = {r_q[PayW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(PayW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quot = (r_den == '0) ? '0 : r_q;
endmodule
`default_nettype wire

/* rtl/core/greedy_deadline_job_scheduler_unit.sv */
// Channel  | Direction | Signals                                   | Transaction
// input    | in        | start, busy, i_deadline/payment/last_job  | start & !busy
// config   | in        | i_cfg_valid, o_cfg_ready, i_cfg_data      | valid & ready
// result   | out       | o_strobe, o_slot ... o_last_slot          | strobe, one cycle
// A job first has its key divided, then, unless the job memory is full, writes its entry
// and is inserted by reading and comparing each stored job, shifting those it passes.
// A last job then runs the slot scan: per slot, sorted entries are read and checked
// until a fit is found or all are examined, then one result is emitted for the slot.
// Reset is synchronous and clears control state and the taken flags.
// Results cannot be stalled; busy stays high until the last result has gone out.
`default_nettype none
module greedy_deadline_job_scheduler_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [gdjs_pkg::DlW-1:0]  i_deadline,
    input  wire logic [gdjs_pkg::PayW-1:0] i_payment,
    input  wire logic                      i_last_job,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [gdjs_pkg::SlotW-1:0] i_cfg_data,
    output logic                           o_strobe,
    output logic [gdjs_pkg::SlotW-1:0]     o_slot,
    output logic [gdjs_pkg::DlW-1:0]       o_slot_deadline,
    output logic [gdjs_pkg::PayW-1:0]      o_slot_payment,
    output logic                           o_filled,
    output logic                           o_last_slot
);
    import gdjs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV   = 9'b000000010,
        S_WJOB  = 9'b000000100,
        S_IRD   = 9'b000001000,
        S_ICMP  = 9'b000010000,
        S_SINIT = 9'b000100000,
        S_SRD   = 9'b001000000,
        S_SCHK  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state r_state;

    // Job memory indexed by load order; order memory holds job indices in sorted order.
    t_job           job_mem [MaxJobs];
    logic [IdxW-1:0] ord_mem [MaxJobs];
    logic [MaxJobs-1:0] r_taken;

    t_job            r_job_rd;
    logic [IdxW-1:0] r_ord_rd;
    logic [IdxW-1:0] job_ra, ord_ra;

    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_pos;
    logic [SlotW-1:0] r_max_time;
    logic [SlotW-1:0] r_slot, r_nslots;
    logic            r_last, r_drop;
    logic [DlW-1:0]  r_dl;
    logic [PayW-1:0] r_pay;
    logic            r_found;
    t_job            r_hit;
    logic            r_ph;

    logic            div_done;
    logic [KeyW-1:0] div_q;
    logic [KeyW-1:0] r_key;

    gdjs_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start && !busy),
        .i_num  (i_payment),
        .i_den  (i_deadline),
        .o_done (div_done),
        .o_quot (div_q)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // Read addresses: insertion reads position pos-1, scan reads position pos.
    always_comb begin
        ord_ra = (r_state == S_IRD || r_state == S_ICMP) ? IdxW'(r_pos - CntW'(1))
                                                         : r_pos[IdxW-1:0];
        job_ra = r_ord_rd;
    end

    always_ff @(posedge i_clk) begin
        r_ord_rd <= ord_mem[ord_ra];
        r_job_rd <= job_mem[job_ra];
    end

    logic [SlotW:0] nsl;
    always_comb begin
        nsl = {1'b0, r_max_time};
        if (nsl > (SlotW+1)'(MaxSlots)) nsl = (SlotW+1)'(MaxSlots);
        if (CntW'(nsl) > r_count) nsl = (SlotW+1)'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_taken    <= '0;
            r_max_time <= MaxTimeReset;
            o_strobe   <= 1'b0;
            r_ph       <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) r_max_time <= i_cfg_data;
                    if (start) begin
                        r_dl    <= i_deadline;
                        r_pay   <= i_payment;
                        r_last  <= i_last_job;
                        r_drop  <= (r_count >= CntW'(MaxJobs));
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (div_done) begin
                    r_key <= div_q;
                    r_pos <= r_count;
                    r_state <= r_drop ? S_SINIT : S_WJOB;
                end
                S_WJOB: begin
                    job_mem[r_count[IdxW-1:0]] <= '{deadline: r_dl, payment: r_pay,
                                                   key: r_key};
                    r_state <= S_IRD;
                    r_ph    <= 1'b0;
                end
                S_IRD: begin
                    if (r_pos == '0) begin
                        ord_mem[r_pos[IdxW-1:0]] <= r_count[IdxW-1:0];
                        r_count <= r_count + CntW'(1);
                        r_state <= r_last ? S_SINIT : S_IDLE;
                    end else begin
                        r_state <= S_ICMP;
                        r_ph    <= 1'b0;
                    end
                end
                S_ICMP: begin
                    // Phase 0 waits for the job read, phase 1 compares the keys.
                    if (!r_ph) r_ph <= 1'b1;
                    else if (r_job_rd.key < r_key) begin
                        ord_mem[r_pos[IdxW-1:0]] <= r_ord_rd;
                        r_pos   <= r_pos - CntW'(1);
                        r_state <= S_IRD;
                    end else begin
                        ord_mem[r_pos[IdxW-1:0]] <= r_count[IdxW-1:0];
                        r_count <= r_count + CntW'(1);
                        r_state <= r_last ? S_SINIT : S_IDLE;
                    end
                end
                S_SINIT: begin
                    if (!r_last) r_state <= S_IDLE;
                    else if (nsl == '0) begin
                        r_count <= '0;
                        r_taken <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_nslots <= SlotW'(nsl);
                        r_slot   <= SlotW'(1);
                        r_pos    <= '0;
                        r_found  <= 1'b0;
                        r_ph     <= 1'b0;
                        r_state  <= S_SRD;
                    end
                end
                S_SRD: begin
                    // Order read issued for r_pos; phase 0 waits for it, phase 1 for the job entry.
                    if (!r_ph) r_ph <= 1'b1;
                    else begin
                        r_ph    <= 1'b0;
                        r_state <= S_SCHK;
                    end
                end
                S_SCHK: begin
                    if (!r_taken[r_ord_rd] &&
                        {1'b0, r_job_rd.deadline} >= {{(DlW+1-SlotW){1'b0}}, r_slot}) begin
                        r_taken[r_ord_rd] <= 1'b1;
                        r_found <= 1'b1;
                        r_hit   <= r_job_rd;
                        r_state <= S_EMIT;
                    end else if (r_pos + CntW'(1) >= r_count) begin
                        r_found <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_pos   <= r_pos + CntW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_EMIT: begin
                    o_strobe        <= 1'b1;
                    o_slot          <= r_slot;
                    o_filled        <= r_found;
                    o_slot_deadline <= r_found ? r_hit.deadline : '0;
                    o_slot_payment  <= r_found ? r_hit.payment : '0;
                    o_last_slot     <= (r_slot == r_nslots);
                    if (r_slot == r_nslots) begin
                        r_count <= '0;
                        r_taken <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_slot  <= r_slot + SlotW'(1);
                        r_pos   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_slot != '0)
        else $error("slot number zero emitted");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_filled) |-> (o_slot_deadline == '0 && o_slot_payment == '0))
        else $error("empty slot carries job data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxJobs))
        else $error("job count beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_slot) |-> !busy)
        else $error("busy after final slot");
endmodule
`default_nettype wire
